### design/rph_pkg.sv
// shared types and constants of the ring pixel hit tester
package rph_pkg;

    localparam int PX_W     = 7;
    localparam int PY_W     = 6;
    localparam int SLOT_W   = 4;
    localparam int POS_W    = 16;
    localparam int LEN_W    = 12;
    localparam int HI_W     = 13;
    localparam int D_W      = 17;
    localparam int SQ_W     = 31;
    localparam int D2_W     = 32;
    localparam int HI2_W    = 26;
    localparam int LO2_W    = 24;
    localparam int EDIT_W   = 5;
    localparam int ID_W     = 7;
    localparam int SCR_W    = 11;
    localparam int SCREEN_W = 128;
    localparam int SCREEN_H = 64;

    localparam logic [EDIT_W-1:0] EDIT_RESET = 5'd16;

    typedef enum logic [1:0] {
        OP_TEST  = 2'd0,
        OP_WRITE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_FRAME = 2'd3
    } t_op;

    // pixel test moving down the cell row
    typedef struct packed {
        logic            v;
        logic [PX_W-1:0] px;
        logic [PY_W-1:0] py;
        logic            lit;
    } t_tok;

    // slot write or clear broadcast to every cell
    typedef struct packed {
        logic                    en;
        logic                    clr;
        logic [SLOT_W-1:0]       slot;
        logic signed [POS_W-1:0] cx;
        logic signed [POS_W-1:0] cy;
        logic [HI_W-1:0]         hi;
        logic [LEN_W-1:0]        lo;
        logic                    lo_en;
    } t_wr;

endpackage

### design/rph_cell.sv
// one table slot with its ring test stage
module rph_cell #(
    parameter int IDX = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rph_pkg::t_wr                  i_wr,
    input  logic                          i_blink,
    input  logic [rph_pkg::EDIT_W-1:0]    i_edit_slot,
    input  rph_pkg::t_tok                 i_tok,
    output rph_pkg::t_tok                 o_tok
);

    localparam logic [rph_pkg::ID_W-1:0] CELL_ID = rph_pkg::ID_W'(IDX);

    logic                             r_valid;
    logic signed [rph_pkg::POS_W-1:0] r_cx;
    logic signed [rph_pkg::POS_W-1:0] r_cy;
    logic [rph_pkg::HI_W-1:0]         r_hi;
    logic [rph_pkg::LEN_W-1:0]        r_lo;
    logic                             r_lo_en;

    logic                             r_tv;
    logic [rph_pkg::PX_W-1:0]         r_px;
    logic [rph_pkg::PY_W-1:0]         r_py;
    logic                             r_lit;
    logic [rph_pkg::SQ_W-1:0]         r_dx2;
    logic [rph_pkg::SQ_W-1:0]         r_dy2;
    logic [rph_pkg::HI2_W-1:0]        r_hi2;
    logic [rph_pkg::LO2_W-1:0]        r_lo2;

    logic                             w_sel;
    logic                             w_hidden;
    logic signed [rph_pkg::D_W-1:0]   w_dx;
    logic signed [rph_pkg::D_W-1:0]   w_dy;
    logic signed [2*rph_pkg::D_W-1:0] w_dx2;
    logic signed [2*rph_pkg::D_W-1:0] w_dy2;
    logic [rph_pkg::HI2_W-1:0]        w_hi2;
    logic [rph_pkg::LO2_W-1:0]        w_lo2;
    logic [rph_pkg::D2_W-1:0]         w_d2;
    logic                             w_hit;

    function automatic logic [rph_pkg::D_W-1:0] i_cx_ext(
        input logic signed [rph_pkg::POS_W-1:0] c
    );
        i_cx_ext = {c[rph_pkg::POS_W-1], c};
    endfunction

    assign w_sel    = ({3'b000, i_wr.slot} == CELL_ID);
    assign w_hidden = i_blink && ({2'b00, i_edit_slot} == CELL_ID);

    // pixel and center in q.4, differences fit 17 bits signed
    assign w_dx  = $signed({6'b000000, i_tok.px, 4'b0000}) - $signed({i_cx_ext(r_cx)});
    assign w_dy  = $signed({7'b0000000, i_tok.py, 4'b0000}) - $signed({i_cx_ext(r_cy)});
    assign w_dx2 = w_dx * w_dx;
    assign w_dy2 = w_dy * w_dy;
    assign w_hi2 = rph_pkg::HI2_W'(r_hi) * rph_pkg::HI2_W'(r_hi);
    assign w_lo2 = rph_pkg::LO2_W'(r_lo) * rph_pkg::LO2_W'(r_lo);

    assign w_d2  = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign w_hit = r_valid && !w_hidden
                && (w_d2 <= {6'd0, r_hi2})
                && (!r_lo_en || (w_d2 >= {8'd0, r_lo2}));

    assign o_tok.v   = r_tv;
    assign o_tok.px  = r_px;
    assign o_tok.py  = r_py;
    assign o_tok.lit = r_lit || (r_tv && w_hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tv    <= 1'b0;
        end else begin
            r_tv <= i_tok.v;
            if (i_wr.en && w_sel) begin
                r_valid <= !i_wr.clr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && w_sel) begin
            r_cx    <= i_wr.cx;
            r_cy    <= i_wr.cy;
            r_hi    <= i_wr.hi;
            r_lo    <= i_wr.lo;
            r_lo_en <= i_wr.lo_en;
        end
        r_px  <= i_tok.px;
        r_py  <= i_tok.py;
        r_lit <= i_tok.lit;
        r_dx2 <= w_dx2[rph_pkg::SQ_W-1:0];
        r_dy2 <= w_dy2[rph_pkg::SQ_W-1:0];
        r_hi2 <= w_hi2;
        r_lo2 <= w_lo2;
    end

endmodule

### design/rph_cfg.sv
// configuration register port holding the edit slot
module rph_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [rph_pkg::EDIT_W-1:0]    o_edit_slot
);

    logic [rph_pkg::EDIT_W-1:0] r_edit_slot;
    logic                       w_wr;

    assign pready      = 1'b1;
    assign w_wr        = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign o_edit_slot = r_edit_slot;

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == 1'b0) begin
            prdata = {27'd0, r_edit_slot};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edit_slot <= rph_pkg::EDIT_RESET;
        end else if (w_wr) begin
            r_edit_slot <= pwdata[rph_pkg::EDIT_W-1:0];
        end
    end

endmodule

### design/ring_pixel_hit_test.sv
// ring object table and pixel hit tester, top level
//
// Input channel (i_in_valid / o_in_ready) takes one item: test a pixel,
// write a slot, clear a slot or end a frame. Output channel
// (o_out_valid / i_out_ready) returns one item with o_pixel_lit for each
// input item, in order; it is 0 for anything but a lit pixel test.
// Items are worked one at a time. A pixel test walks a row of
// MAX_OBJECTS cells, one slot per cell per cycle. A write, clear or
// frame end, and a test of a pixel off screen, skip the row and go
// from the execute state straight to the done state. A new item is
// taken once the previous one has reached the output register.
// If the receiver stalls, the finished item waits in the output
// register, the next item is still accepted and worked, and its result
// waits until the register frees.
// The edit slot register sits at byte address 0 of the APB port, and
// the slot it names is hidden on every other frame. Reset empties the
// table, clears the blink phase and sets the edit slot to 16 (no slot).
module ring_pixel_hit_test #(
    parameter int MAX_OBJECTS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_operation,
    input  logic [rph_pkg::PX_W-1:0]         i_pixel_x,
    input  logic [rph_pkg::PY_W-1:0]         i_pixel_y,
    input  logic [rph_pkg::SLOT_W-1:0]       i_slot,
    input  logic signed [rph_pkg::POS_W-1:0] i_center_x,
    input  logic signed [rph_pkg::POS_W-1:0] i_center_y,
    input  logic [rph_pkg::LEN_W-1:0]        i_radius,
    input  logic [rph_pkg::LEN_W-1:0]        i_thickness,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_pixel_lit,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT,
        S_DONE
    } t_state;

    t_state                           r_state;
    logic                             r_blink;
    logic                             r_res;
    logic                             r_out_valid;
    logic                             r_out_lit;

    rph_pkg::t_op                     r_op;
    logic [rph_pkg::PX_W-1:0]         r_px;
    logic [rph_pkg::PY_W-1:0]         r_py;
    logic [rph_pkg::SLOT_W-1:0]       r_slot;
    logic signed [rph_pkg::POS_W-1:0] r_cx;
    logic signed [rph_pkg::POS_W-1:0] r_cy;
    logic [rph_pkg::HI_W-1:0]         r_hi;
    logic [rph_pkg::LEN_W-1:0]        r_lo;
    logic                             r_lo_en;

    logic                             w_in_acc;
    logic                             w_out_free;
    logic                             w_onscreen;
    logic [rph_pkg::EDIT_W-1:0]       w_edit_slot;
    rph_pkg::t_wr                     w_wr;
    rph_pkg::t_tok                    w_tok [MAX_OBJECTS+1];
    logic [MAX_OBJECTS-1:0]           w_tv;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_pixel_lit = r_out_lit;

    assign w_onscreen = ({4'd0, r_px} < rph_pkg::SCR_W'(rph_pkg::SCREEN_W))
                     && ({5'd0, r_py} < rph_pkg::SCR_W'(rph_pkg::SCREEN_H));

    assign w_wr.en    = (r_state == S_EXEC)
                     && ((r_op == rph_pkg::OP_WRITE) || (r_op == rph_pkg::OP_CLEAR));
    assign w_wr.clr   = (r_op == rph_pkg::OP_CLEAR);
    assign w_wr.slot  = r_slot;
    assign w_wr.cx    = r_cx;
    assign w_wr.cy    = r_cy;
    assign w_wr.hi    = r_hi;
    assign w_wr.lo    = r_lo;
    assign w_wr.lo_en = r_lo_en;

    assign w_tok[0].v   = (r_state == S_EXEC) && (r_op == rph_pkg::OP_TEST) && w_onscreen;
    assign w_tok[0].px  = r_px;
    assign w_tok[0].py  = r_py;
    assign w_tok[0].lit = 1'b0;

    rph_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_edit_slot (w_edit_slot)
    );

    for (genvar k = 0; k < MAX_OBJECTS; k++) begin : g_cell
        rph_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_wr        (w_wr),
            .i_blink     (r_blink),
            .i_edit_slot (w_edit_slot),
            .i_tok       (w_tok[k]),
            .o_tok       (w_tok[k+1])
        );
        assign w_tv[k] = w_tok[k+1].v;
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op    <= rph_pkg::t_op'(i_operation);
            r_px    <= i_pixel_x;
            r_py    <= i_pixel_y;
            r_slot  <= i_slot;
            r_cx    <= i_center_x;
            r_cy    <= i_center_y;
            r_hi    <= {1'b0, i_radius} + {1'b0, i_thickness};
            r_lo    <= i_radius - i_thickness;
            r_lo_en <= (i_radius >= i_thickness);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_blink     <= 1'b0;
            r_res       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_lit   <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
                r_out_lit   <= r_res;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_res <= 1'b0;
                    if (r_op == rph_pkg::OP_FRAME) begin
                        r_blink <= !r_blink;
                    end
                    if ((r_op == rph_pkg::OP_TEST) && w_onscreen) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_WAIT: begin
                    if (w_tok[MAX_OBJECTS].v) begin
                        r_res   <= w_tok[MAX_OBJECTS].lit;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_one_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_tv) <= 1)
        else $error("more than one pixel test in the cell row");

    a_tok_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[MAX_OBJECTS].v |-> (r_state == S_WAIT))
        else $error("test left the cell row outside the wait state");

    a_acc_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_EXEC))
        else $error("accepted item not executed next cycle");

    a_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result shown without a finished item");

endmodule
